@@ sv/distinct_range_partition_assert.svh @@
// assertion macros used by the port level checker of the range partition block
`ifndef DISTINCT_RANGE_PARTITION_ASSERT_SVH
`define DISTINCT_RANGE_PARTITION_ASSERT_SVH

// checked on every edge out of reset
`define DRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define DRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/drp_pkg.sv @@
// types and constants of the range partition block
`default_nettype none

package drp_pkg;

  localparam int unsigned DRP_DEPTH     = 64;
  localparam int unsigned DRP_CHAR_BITS = 9;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DUMP   = 2'd2
  } drp_op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } drp_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_MOVE,
    S_PUT_E,
    S_PUT_B,
    S_DUMP
  } drp_state_e;

endpackage

`default_nettype wire

@@ sv/drp_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module drp_ram #(
  parameter int unsigned WIDTH = drp_pkg::DRP_CHAR_BITS + 1,
  parameter int unsigned DEPTH = drp_pkg::DRP_DEPTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/distinct_range_partition.sv @@
// top level of the character range partition block
`default_nettype none

// Keeps a sorted list of character boundaries, each with an inside flag, in one
// DEPTH-entry ram with one write and one registered read port. A command is taken
// when start is high and busy is low; every result appears for exactly one cycle
// with valid_o high and cannot be held off, so the user must take it then.
// Steps of each command:
//   clear, insert with a bad range, dump of an empty list: result registered
//   in the cycle after the transfer, block ready again at once
//   insert: one read per cycle to scan the list, a full-check step, a
//   top-down move of the entries at or above the begin point through the
//   same ram port, then writes of the new end and begin boundaries; the
//   move and the writes are skipped when the table turns out full
//   dump: one boundary per cycle
// The single ram read port sets this pace. Opcode 3 is ignored.
// Stored entries are never cleared: only the first entry count entries are read.

module distinct_range_partition #(
  parameter int unsigned DEPTH     = drp_pkg::DRP_DEPTH,
  parameter int unsigned CHAR_BITS = drp_pkg::DRP_CHAR_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [CHAR_BITS-1:0] range_begin_i,
  input  wire logic [CHAR_BITS-1:0] range_end_i,
  output logic                      valid_o,
  output logic [1:0]                status_o,
  output logic [CHAR_BITS-1:0]      boundary_o,
  output logic                      inside_res_o,
  output logic                      is_empty_o,
  output logic                      last_o
);

  import drp_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);      // ram address
  localparam int unsigned CW = $clog2(DEPTH + 1);  // entry count, can hold DEPTH
  localparam int unsigned EW = CHAR_BITS + 1;      // {inside, char}
  localparam logic [CW:0] DepthLimit = (CW + 1)'(DEPTH);

  // control state
  drp_state_e    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;          // number of valid entries
  logic [CW-1:0] ptr_q, ptr_d;          // next read address (scan, dump) or one above (move)
  logic          rd_vld_q, rd_vld_d;    // ram read data valid this cycle
  logic [CW-1:0] rd_idx_q, rd_idx_d;    // address the read data came from

  // insert bookkeeping gathered during the scan
  logic [CW-1:0] pos_q, pos_d;          // entries below begin
  logic [CW-1:0] qi_q, qi_d;            // entries below end
  logic          hasb_q, hasb_d;
  logic          hase_q, hase_d;
  logic          endflag_q, endflag_d;  // flag of the last entry below end

  // captured range
  logic [CHAR_BITS-1:0] b_q, e_q;

  // result register
  logic                 valid_q, valid_d;
  drp_status_e          status_q, status_d;
  logic [CHAR_BITS-1:0] boundary_q, boundary_d;
  logic                 inside_q, inside_d;
  logic                 empty_q, empty_d;
  logic                 last_q, last_d;

  // ram port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  // read data split and the shared compare unit
  logic [CHAR_BITS-1:0] rd_ch;
  logic                 rd_in;
  logic                 lt_b, eq_b, lt_e, eq_e;
  logic [CW-1:0]        s1, s2;         // one if begin / end boundary is new
  logic [CW-1:0]        mv_addr;
  logic [CW:0]          need;

  assign rd_ch = ram_rdata[CHAR_BITS-1:0];
  assign rd_in = ram_rdata[CHAR_BITS];
  assign lt_b  = rd_ch < b_q;
  assign eq_b  = rd_ch == b_q;
  assign lt_e  = rd_ch < e_q;
  assign eq_e  = rd_ch == e_q;

  assign s1 = CW'(!hasb_q);
  assign s2 = CW'(!hase_q);

  // entries between begin and end move up past a new begin boundary,
  // entries from end upward also past a new end boundary
  assign mv_addr = (rd_idx_q < qi_q) ? (rd_idx_q + s1) : (rd_idx_q + s1 + s2);
  assign need    = {1'b0, cnt_q} + (CW + 1)'(!hasb_q) + (CW + 1)'(!hase_q);

  drp_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      pos_q     <= '0;
      qi_q      <= '0;
      hasb_q    <= 1'b0;
      hase_q    <= 1'b0;
      endflag_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ptr_q     <= ptr_d;
      rd_vld_q  <= rd_vld_d;
      rd_idx_q  <= rd_idx_d;
      pos_q     <= pos_d;
      qi_q      <= qi_d;
      hasb_q    <= hasb_d;
      hase_q    <= hase_d;
      endflag_q <= endflag_d;
      valid_q   <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      b_q <= range_begin_i;
      e_q <= range_end_i;
    end
    status_q   <= status_d;
    boundary_q <= boundary_d;
    inside_q   <= inside_d;
    empty_q    <= empty_d;
    last_q     <= last_d;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    pos_d      = pos_q;
    qi_d       = qi_q;
    hasb_d     = hasb_q;
    hase_d     = hase_q;
    endflag_d  = endflag_q;
    valid_d    = 1'b0;
    status_d   = ST_OK;
    boundary_d = '0;
    inside_d   = 1'b0;
    empty_d    = 1'b0;
    last_d     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (drp_op_e'(opcode_i))
            OP_CLEAR: begin
              cnt_d   = '0;
              valid_d = 1'b1;
              last_d  = 1'b1;
            end
            OP_INSERT: begin
              if (range_begin_i >= range_end_i) begin
                valid_d  = 1'b1;
                status_d = ST_BAD;
                last_d   = 1'b1;
              end else begin
                state_d   = S_SCAN;
                ptr_d     = '0;
                pos_d     = '0;
                qi_d      = '0;
                hasb_d    = 1'b0;
                hase_d    = 1'b0;
                endflag_d = 1'b0;
              end
            end
            OP_DUMP: begin
              if (cnt_q == '0) begin
                valid_d = 1'b1;
                empty_d = 1'b1;
                last_d  = 1'b1;
              end else begin
                state_d = S_DUMP;
                ptr_d   = '0;
              end
            end
            default: begin
              // unused opcode, nothing to do
            end
          endcase
        end
      end

      // one entry per cycle: count entries below begin and end, note matches
      S_SCAN: begin
        if (ptr_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[AW-1:0];
          ptr_d     = ptr_q + CW'(1);
          rd_vld_d  = 1'b1;
          rd_idx_d  = ptr_q;
        end else if (!rd_vld_q) begin
          state_d = S_CHECK;
        end
        if (rd_vld_q) begin
          if (lt_b) begin
            pos_d = pos_q + CW'(1);
          end
          if (eq_b) begin
            hasb_d = 1'b1;
          end
          if (lt_e) begin
            qi_d      = qi_q + CW'(1);
            endflag_d = rd_in;
          end
          if (eq_e) begin
            hase_d = 1'b1;
          end
        end
      end

      S_CHECK: begin
        if (need > DepthLimit) begin
          valid_d  = 1'b1;
          status_d = ST_FULL;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_MOVE;
          ptr_d   = cnt_q;
        end
      end

      // top down, so an entry is read before anything lands on it
      S_MOVE: begin
        if (ptr_q > pos_q) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_q - CW'(1));
          ptr_d     = ptr_q - CW'(1);
          rd_vld_d  = 1'b1;
          rd_idx_d  = ptr_q - CW'(1);
        end else if (!rd_vld_q) begin
          state_d = S_PUT_E;
        end
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = mv_addr[AW-1:0];
          ram_wdata = (rd_idx_q < qi_q) ? {1'b1, rd_ch} : ram_rdata;
        end
      end

      S_PUT_E: begin
        if (!hase_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(qi_q + s1);
          ram_wdata = {endflag_q, e_q};
        end
        state_d = S_PUT_B;
      end

      S_PUT_B: begin
        if (!hasb_q) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[AW-1:0];
          ram_wdata = {1'b1, b_q};
        end
        cnt_d   = cnt_q + s1 + s2;
        valid_d = 1'b1;
        last_d  = 1'b1;
        state_d = S_IDLE;
      end

      // stream the list out, one boundary per cycle
      S_DUMP: begin
        if (ptr_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[AW-1:0];
          ptr_d     = ptr_q + CW'(1);
          rd_vld_d  = 1'b1;
          rd_idx_d  = ptr_q;
        end else if (!rd_vld_q) begin
          state_d = S_IDLE;
        end
        if (rd_vld_q) begin
          valid_d    = 1'b1;
          boundary_d = rd_ch;
          inside_d   = rd_in;
          last_d     = rd_idx_q == (cnt_q - CW'(1));
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy         = state_q != S_IDLE;
  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign boundary_o   = boundary_q;
  assign inside_res_o = inside_q;
  assign is_empty_o   = empty_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

@@ sv/drp_checker.sv @@
// port level checks of the range partition block and their bind
`default_nettype none

`include "distinct_range_partition_assert.svh"

module drp_checker #(
  parameter int unsigned CHAR_BITS = drp_pkg::DRP_CHAR_BITS
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic [1:0]           opcode_i,
  input wire logic [CHAR_BITS-1:0] range_begin_i,
  input wire logic [CHAR_BITS-1:0] range_end_i,
  input wire logic                 valid_o,
  input wire logic [1:0]           status_o,
  input wire logic [CHAR_BITS-1:0] boundary_o,
  input wire logic                 inside_res_o,
  input wire logic                 is_empty_o,
  input wire logic                 last_o
);

  import drp_pkg::*;

  // clear answers on the next cycle
  `DRP_ASSERT(a_clear_resp, start && !busy && opcode_i == OP_CLEAR |=> valid_o && last_o && status_o == ST_OK, "clear not answered next cycle")

  // a reversed or empty range is refused at once
  `DRP_ASSERT(a_bad_range, start && !busy && opcode_i == OP_INSERT && range_begin_i >= range_end_i |=> valid_o && last_o && status_o == ST_BAD, "bad range not refused")

  // error status and empty dump are single results with zero payload
  `DRP_ASSERT(a_single_res, valid_o && (is_empty_o || status_o != ST_OK) |-> last_o && boundary_o == '0 && !inside_res_o, "single result malformed")

  // the block stays quiet during reset
  `DRP_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !valid_o && !busy, "activity during reset")

endmodule

bind distinct_range_partition drp_checker #(.CHAR_BITS(CHAR_BITS)) u_drp_checker (.*);

`default_nettype wire

@@ verif/drp_checker.sv @@
// scoreboard for the range partition block: mirrors the boundary list and checks every result
module drp_scoreboard (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic [1:0]                        opcode_i,
  input  logic [drp_pkg::DRP_CHAR_BITS-1:0] range_begin_i,
  input  logic [drp_pkg::DRP_CHAR_BITS-1:0] range_end_i,
  input  logic                              res_valid_i,
  input  logic [1:0]                        res_status_i,
  input  logic [drp_pkg::DRP_CHAR_BITS-1:0] res_boundary_i,
  input  logic                              res_inside_i,
  input  logic                              res_is_empty_i,
  input  logic                              res_last_i,
  output int                                mismatch_count_o,
  output int                                awaited_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import drp_pkg::*;

  typedef logic [DRP_CHAR_BITS-1:0] char_t;

  typedef struct packed {
    char_t ch;
    logic  covered;
  } mark_t;

  typedef struct packed {
    drp_status_e status;
    char_t       ch;
    logic        covered;
    logic        empty;
    logic        last;
  } outcome_t;

  mark_t    marks[$];    // sorted boundary list as the block should hold it
  outcome_t awaited[$];  // results predicted but not yet seen
  int       errors;

  task automatic report_mismatch(string what);
    $display("[%0t] drp_scoreboard: %s", $realtime, what);
    errors++;
  endtask

  // appends one predicted result behind the ones still outstanding
  task automatic add_awaited(outcome_t r);
    awaited.insert(awaited.size(), r);
  endtask

  // splits [lo, hi) into the list, same rules for full table and bad range
  function automatic drp_status_e partition_insert(char_t lo, char_t hi);
    int    pos;
    int    q;
    int    grow;
    bit    has_lo;
    bit    has_hi;
    logic  hi_flag;
    mark_t m;
    if (lo >= hi) return ST_BAD;
    pos = 0;
    while (pos < marks.size() && marks[pos].ch < lo) pos++;
    has_lo = (pos < marks.size()) && (marks[pos].ch == lo);
    q = pos;
    while (q < marks.size() && marks[q].ch < hi) q++;
    has_hi = (q < marks.size()) && (marks[q].ch == hi);
    hi_flag = (q > 0) ? marks[q-1].covered : 1'b0;
    grow = (has_lo ? 0 : 1) + (has_hi ? 0 : 1);
    if (marks.size() + grow > int'(DRP_DEPTH)) return ST_FULL;
    for (int k = pos; k < q; k++) marks[k].covered = 1'b1;
    // end goes in first so that pos still points at the right slot
    if (!has_hi) begin
      m.ch = hi;
      m.covered = hi_flag;
      marks.insert(q, m);
    end
    if (!has_lo) begin
      m.ch = lo;
      m.covered = 1'b1;
      marks.insert(pos, m);
    end
    return ST_OK;
  endfunction

  task automatic predict_command(logic [1:0] op, char_t lo, char_t hi);
    outcome_t r;
    r = '0;
    r.last = 1'b1;
    case (op)
      OP_CLEAR: begin
        marks.delete();
        add_awaited(r);
      end
      OP_INSERT: begin
        r.status = partition_insert(lo, hi);
        add_awaited(r);
      end
      OP_DUMP: begin
        if (marks.size() == 0) begin
          r.empty = 1'b1;
          add_awaited(r);
        end else begin
          for (int k = 0; k < marks.size(); k++) begin
            r.ch = marks[k].ch;
            r.covered = marks[k].covered;
            r.last = (k == marks.size() - 1);
            add_awaited(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : watch
    outcome_t want;
    if (rst_ni) begin
      if (res_valid_i) begin
        if (awaited.size() == 0) begin
          report_mismatch("result arrived with nothing outstanding");
        end else begin
          want = awaited.pop_front();
          if (res_status_i !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", res_status_i, want.status));
          if (res_boundary_i !== want.ch)
            report_mismatch($sformatf("boundary got %0d want %0d", res_boundary_i, want.ch));
          if (res_inside_i !== want.covered)
            report_mismatch($sformatf("inside got %0b want %0b", res_inside_i, want.covered));
          if (res_is_empty_i !== want.empty)
            report_mismatch($sformatf("is_empty got %0b want %0b", res_is_empty_i, want.empty));
          if (res_last_i !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", res_last_i, want.last));
        end
      end
      if (start_i && !busy_i) predict_command(opcode_i, range_begin_i, range_end_i);
      awaited_count_o <= awaited.size();
      mismatch_count_o <= errors;
    end
  end

endmodule

@@ verif/tb_top.sv @@
// testbench top of the range partition block: stimulus, watchdog and verdict
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import drp_pkg::*;

  typedef logic [DRP_CHAR_BITS-1:0] char_t;

  // opcode 3 has no meaning: the block must ignore it
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int CHAR_TOP = (1 << DRP_CHAR_BITS) - 1;
  // longest stretch with neither a command transfer nor a result; it must hold
  // an insert into a nearly full table, the rest is room for sender gaps
  localparam int STALL_LIMIT = 4000;
  // cycles left after the last result so stray results still get caught
  localparam int DRAIN_CYCLES = 200;
  // general random commands per random phase, reserved opcodes not counted
  localparam int RANDOM_PER_PHASE = 12;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  logic  [1:0] opcode_i = OP_CLEAR;
  char_t range_begin_i = '0;
  char_t range_end_i = '0;
  logic  valid_o;
  logic  [1:0] status_o;
  char_t boundary_o;
  logic  inside_res_o;
  logic  is_empty_o;
  logic  last_o;

  int mismatch_count;
  int awaited_count;
  int gap_pct = 0;   // chance in percent that the sender sits idle for a cycle
  int stall_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  distinct_range_partition dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .range_begin_i(range_begin_i),
    .range_end_i  (range_end_i),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .boundary_o   (boundary_o),
    .inside_res_o (inside_res_o),
    .is_empty_o   (is_empty_o),
    .last_o       (last_o)
  );

  drp_scoreboard u_scoreboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .opcode_i        (opcode_i),
    .range_begin_i   (range_begin_i),
    .range_end_i     (range_end_i),
    .res_valid_i     (valid_o),
    .res_status_i    (status_o),
    .res_boundary_i  (boundary_o),
    .res_inside_i    (inside_res_o),
    .res_is_empty_i  (is_empty_o),
    .res_last_i      (last_o),
    .mismatch_count_o(mismatch_count),
    .awaited_count_o (awaited_count)
  );

  // watchdog: any transfer or result restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // half the time a multiple of 16, so boundaries get hit again and again
  function automatic int pick_char();
    if ($urandom_range(1) == 0) return 16 * $urandom_range(CHAR_TOP / 16);
    return $urandom_range(CHAR_TOP);
  endfunction

  // one command transfer; start stays high when the next one follows at once.
  // busy only moves at rising edges, so its value at the falling edge tells
  // whether the coming rising edge takes the command
  task automatic issue(logic [1:0] op, int lo, int hi);
    while ($urandom_range(99) < gap_pct) begin
      // idle cycle, field noise must not matter while start is low
      start <= 1'b0;
      opcode_i <= 2'($urandom_range(3));
      range_begin_i <= char_t'($urandom_range(CHAR_TOP));
      range_end_i <= char_t'($urandom_range(CHAR_TOP));
      @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    range_begin_i <= char_t'(lo);
    range_end_i <= char_t'(hi);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int pick;
    int lo;
    int hi;
    int room;
    int swap;
    int counted;
    int stride;
    int base;
    int rot;
    int k;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: empty dump, overlaps, shared boundaries, extremes, bad ranges
    issue(OP_DUMP, 0, 0);
    issue(OP_INSERT, 100, 200);
    issue(OP_INSERT, 150, 300);           // overlap, new end keeps an uncovered flag
    issue(OP_INSERT, 100, 150);           // both boundaries already stored
    issue(OP_INSERT, 350, 450);
    issue(OP_INSERT, 400, 500);           // begin lands inside a covered piece
    issue(OP_INSERT, 0, 1);
    issue(OP_INSERT, CHAR_TOP - 1, CHAR_TOP);
    issue(OP_DUMP, 0, 0);
    issue(OP_INSERT, 0, CHAR_TOP);        // widest range covers everything
    issue(OP_INSERT, CHAR_TOP, CHAR_TOP); // begin equal to end
    issue(OP_INSERT, CHAR_TOP, 0);        // begin above end
    issue(OP_INSERT, 0, 0);
    issue(OP_RESERVED, CHAR_TOP, CHAR_TOP);
    issue(OP_DUMP, CHAR_TOP, CHAR_TOP);
    issue(OP_CLEAR, CHAR_TOP, CHAR_TOP);
    issue(OP_DUMP, 0, 0);                 // empty again after clear
    issue(OP_INSERT, 256, 257);
    issue(OP_INSERT, 255, 258);
    issue(OP_DUMP, 0, 0);
    issue(OP_CLEAR, 0, 0);

    // random phases; the receiver cannot stall, so only the sender idles.
    // phases 1 and 2 fill the table to the brim, 0 and 3 mix everything
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 63 : (ph == 3) ? 27 : 0;
      if (ph == 1 || ph == 2) begin
        // 33 disjoint ranges need 66 boundaries: the last one in finds the table full
        issue(OP_CLEAR, pick_char(), pick_char());
        stride = $urandom_range(7, 2);
        base = $urandom_range(200);
        rot = $urandom_range(32);
        for (int i = 0; i < 33; i++) begin
          k = (i * 7 + rot) % 33;   // 7 is coprime to 33, so a shuffled order
          lo = base + stride * k;
          issue(OP_INSERT, lo, lo + $urandom_range(stride - 1, 1));
        end
        issue(OP_INSERT, base, base + stride * 5);
        issue(OP_INSERT, base + stride * 33 + 1, base + stride * 33 + 3);
        issue(OP_DUMP, 0, 0);
      end else begin
        counted = 0;
        while (counted < RANDOM_PER_PHASE) begin
          pick = $urandom_range(99);
          lo = pick_char();
          hi = pick_char();
          if (pick < 6) begin
            issue(OP_CLEAR, lo, hi);
          end else if (pick < 18) begin
            issue(OP_DUMP, lo, hi);
          end else if (pick < 22) begin
            issue(OP_RESERVED, lo, hi);
          end else begin
            if (pick < 30) begin
              // bad range: end at or below begin
              if (hi > lo) begin
                swap = lo;
                lo = hi;
                hi = swap;
              end
            end else if (pick < 65 && lo < CHAR_TOP) begin
              // narrow range
              room = CHAR_TOP - lo;
              if (room > 16) room = 16;
              hi = lo + $urandom_range(room, 1);
            end else begin
              // wide range between two picks
              if (lo > hi) begin
                swap = lo;
                lo = hi;
                hi = swap;
              end else if (lo == hi) begin
                if (hi < CHAR_TOP) hi = hi + 1;
                else lo = lo - 1;
              end
            end
            issue(OP_INSERT, lo, hi);
          end
          if (pick < 18 || pick >= 22) counted++;
        end
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
